// ===== rtl/f2i_pkg.sv =====
package f2i_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned ExpWidth  = 11;
    localparam int unsigned FracWidth = 52;

    typedef enum logic [1:0] {
        MODE_FLOOR = 2'd0,
        MODE_CEIL  = 2'd1,
        MODE_TRUNC = 2'd2,
        MODE_HALF  = 2'd3
    } t_mode;

    localparam logic [63:0] PosMax = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NegMax = 64'h8000_0000_0000_0000;

    // decoded operand handed from the input stage to the rounding stage
    typedef struct packed {
        logic        special;
        logic [63:0] special_val;
        logic        neg;
        logic [63:0] mag;
        logic        ge_half;
        logic        frac_nz;
        logic        shifted_up;
        t_mode       mode;
    } t_dec;

endpackage

// ===== rtl/f2i_if.sv =====
interface f2i_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] value_bits;
    modport source (output valid, output op, output value_bits, input ready);
    modport sink (input valid, input op, input value_bits, output ready);
endinterface

interface f2i_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result;
    logic        invalid;
    modport source (output valid, output result, output invalid, input ready);
    modport sink (input valid, input result, input invalid, output ready);
endinterface

// ===== rtl/f2i_decode.sv =====
module f2i_decode
    import f2i_pkg::*;
(
    input  logic [1:0]  i_op,
    input  logic [63:0] i_bits,
    output t_dec        o_dec
);

    logic [10:0] expo;
    logic [51:0] frac;
    logic [52:0] sig;
    logic [11:0] rs;
    logic [52:0] rem_mask;
    logic [52:0] rem;
    logic [52:0] half_mask;

    // field split, special cases, right shift amount, magnitude and rounding flags
    always_comb begin
        expo = i_bits[62:52];
        frac = i_bits[51:0];
        sig  = (expo == '0) ? {1'b0, frac} : {1'b1, frac};
        o_dec = '0;
        o_dec.neg  = i_bits[63];
        o_dec.mode = t_mode'(i_op);
        rs = 12'd0;
        rem_mask = '0;
        rem = '0;
        half_mask = '0;
        if (expo == 11'h7FF) begin
            o_dec.special = 1'b1;
            o_dec.special_val = (frac != '0 || i_bits[63]) ? NegMax : PosMax;
        end else if (expo >= 11'd1075) begin
            o_dec.shifted_up = 1'b1;
            if (expo > 11'd1086) begin
                o_dec.special = 1'b1;
                o_dec.special_val = i_bits[63] ? NegMax : PosMax;
            end else begin
                o_dec.mag = {11'd0, sig} << (expo - 11'd1075);
            end
        end else begin
            rs = (expo == '0) ? 12'd1074 : (12'd1075 - {1'b0, expo});
            if (rs > 12'd53) begin
                o_dec.frac_nz = sig != '0;
            end else begin
                rem_mask  = ~(53'h1F_FFFF_FFFF_FFFF << rs[5:0]);
                rem       = sig & rem_mask;
                half_mask = 53'd1 << (rs[5:0] - 6'd1);
                o_dec.mag = {11'd0, sig >> rs[5:0]};
                o_dec.ge_half = (rem & half_mask) != '0;
                o_dec.frac_nz = rem != '0;
            end
        end
    end

endmodule

// ===== rtl/f2i_round.sv =====
module f2i_round
    import f2i_pkg::*;
(
    input  t_dec        i_dec,
    output logic [63:0] o_result,
    output logic        o_invalid
);

    logic inc;
    logic [64:0] mag;

    // increment decision, sign apply and saturation
    always_comb begin
        inc = 1'b0;
        if (!i_dec.shifted_up) begin
            case (i_dec.mode)
                MODE_FLOOR: inc = i_dec.neg && i_dec.frac_nz;
                MODE_CEIL:  inc = !i_dec.neg && i_dec.frac_nz;
                MODE_TRUNC: inc = 1'b0;
                MODE_HALF:  inc = i_dec.ge_half;
                default:    inc = 1'b0;
            endcase
        end
        mag = {1'b0, i_dec.mag} + {64'd0, inc};
        o_invalid = 1'b0;
        if (i_dec.special) begin
            o_result  = i_dec.special_val;
            o_invalid = 1'b1;
        end else if (i_dec.neg) begin
            if (mag > {1'b0, NegMax}) begin
                o_result  = NegMax;
                o_invalid = 1'b1;
            end else begin
                o_result = 64'd0 - mag[63:0];
            end
        end else if (mag > {1'b0, PosMax}) begin
            o_result  = PosMax;
            o_invalid = 1'b1;
        end else begin
            o_result = mag[63:0];
        end
    end

endmodule

// ===== rtl/float_to_int_rounding_core.sv =====
// channel | dir | payload
// in      | in  | op[1:0], value_bits[63:0]
// out     | out | result[63:0] signed, invalid
// one item per cycle sustained while the result is not stalled; path: input register, decode,
// rounding, result register
// synchronous active-low reset clears both valid flags
// a stalled result holds; the input stage advances when it is empty or when the
// result stage is empty or being drained
module float_to_int_rounding_core
    import f2i_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    f2i_in_if.sink    i_in,
    f2i_out_if.source o_out
);

    logic        r_in_vld;
    logic [1:0]  r_op;
    logic [63:0] r_bits;
    logic        r_out_vld;
    logic [63:0] r_result;
    logic        r_invalid;
    logic        adv_out;
    logic        adv_in;
    t_dec        dec;
    logic [63:0] n_result;
    logic        n_invalid;

    assign adv_out = !r_out_vld || o_out.ready;
    assign adv_in  = !r_in_vld || adv_out;
    assign i_in.ready = adv_in;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (adv_in) begin
            r_in_vld <= i_in.valid;
        end
        if (adv_in && i_in.valid) begin
            r_op   <= i_in.op;
            r_bits <= i_in.value_bits;
        end
    end

    f2i_decode u_dec (.i_op(r_op), .i_bits(r_bits), .o_dec(dec));
    f2i_round  u_rnd (.i_dec(dec), .o_result(n_result), .o_invalid(n_invalid));

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv_out) begin
            r_out_vld <= r_in_vld;
        end
        if (adv_out && r_in_vld) begin
            r_result  <= n_result;
            r_invalid <= n_invalid;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.result  = r_result;
    assign o_out.invalid = r_invalid;

    // a stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |=> r_out_vld && $stable(r_result))
        else $error("stalled result changed");

    // a positive-max result always flags invalid
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_result == PosMax |-> r_invalid)
        else $error("positive max without invalid");

    // accepted item reaches result stage when unstalled
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && adv_out |=> r_out_vld)
        else $error("item lost");

endmodule

// ===== tb/sv/float_to_int_rounding_core_test.sv =====
`timescale 1ns / 100ps

module float_to_int_rounding_core_test;
    import f2i_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    f2i_in_if  in_ch();
    f2i_out_if out_ch();

    float_to_int_rounding_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    typedef struct {
        logic [63:0] result;
        logic        invalid;
    } t_conv;

    typedef struct {
        t_mode       mode;
        logic [63:0] bits;
        logic        known;
        logic [63:0] result;
        logic        invalid;
    } t_row;

    t_conv conv_q[$];
    int    fail_cnt = 0;
    int    sent_cnt = 0;

    always #2 i_clk = ~i_clk;

    // rounded conversion with saturation
    function automatic t_conv convert(t_mode mode, logic [63:0] bits);
        t_conv       r;
        logic        neg;
        logic [10:0] expo;
        logic [51:0] frac;
        logic [63:0] sig;
        logic [63:0] mag;
        logic [63:0] rem;
        int          shift;
        int          rs;
        logic        ge_half;
        logic        frac_nz;
        neg = bits[63];
        expo = bits[62:52];
        frac = bits[51:0];
        ge_half = 1'b0;
        frac_nz = 1'b0;
        r.invalid = 1'b1;
        if (expo == 11'h7FF) begin
            r.result = (frac != '0 || neg) ? NegMax : PosMax;
            return r;
        end
        if (expo == '0) begin
            sig = {12'd0, frac};
            shift = 1 - 1075;
        end else begin
            sig = {11'd0, 1'b1, frac};
            shift = int'(expo) - 1075;
        end
        if (shift >= 0) begin
            if (shift > 11) begin
                r.result = neg ? NegMax : PosMax;
                return r;
            end
            mag = sig << shift;
        end else begin
            rs = -shift;
            if (rs > 53) begin
                mag = '0;
                frac_nz = sig != '0;
            end else begin
                rem = sig & ((64'd1 << rs) - 64'd1);
                mag = sig >> rs;
                ge_half = rem[rs-1];
                frac_nz = rem != '0;
            end
            case (mode)
                MODE_FLOOR: if (neg && frac_nz) mag = mag + 64'd1;
                MODE_CEIL:  if (!neg && frac_nz) mag = mag + 64'd1;
                MODE_TRUNC: ;
                default:    if (ge_half) mag = mag + 64'd1;
            endcase
        end
        if (neg) begin
            if (mag > NegMax) begin
                r.result = NegMax;
                return r;
            end
            r.result = 64'd0 - mag;
        end else begin
            if (mag > PosMax) begin
                r.result = PosMax;
                return r;
            end
            r.result = mag;
        end
        r.invalid = 1'b0;
        return r;
    endfunction

    // directed table: extremes, specials, every mode
    t_row dir_tab[] = '{
        '{MODE_FLOOR, 64'h0000_0000_0000_0000, 1'b1, 64'd0, 1'b0},
        '{MODE_CEIL,  64'h8000_0000_0000_0000, 1'b1, 64'd0, 1'b0},
        '{MODE_TRUNC, 64'h7FF8_0000_0000_0000, 1'b1, NegMax, 1'b1},
        '{MODE_HALF,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, NegMax, 1'b1},
        '{MODE_FLOOR, 64'h7FF0_0000_0000_0000, 1'b1, PosMax, 1'b1},
        '{MODE_CEIL,  64'hFFF0_0000_0000_0000, 1'b1, NegMax, 1'b1},
        '{MODE_TRUNC, 64'h43E0_0000_0000_0000, 1'b1, PosMax, 1'b1},
        '{MODE_TRUNC, 64'hC3E0_0000_0000_0000, 1'b1, NegMax, 1'b0},
        '{MODE_HALF,  64'hC3E0_0000_0000_0001, 1'b1, NegMax, 1'b1},
        '{MODE_FLOOR, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1, PosMax, 1'b1},
        '{MODE_FLOOR, 64'h0000_0000_0000_0001, 1'b0, 64'd0, 1'b0},
        '{MODE_CEIL,  64'h0000_0000_0000_0001, 1'b0, 64'd0, 1'b0},
        '{MODE_FLOOR, 64'h800F_FFFF_FFFF_FFFF, 1'b0, 64'd0, 1'b0},
        '{MODE_HALF,  64'h3FE0_0000_0000_0000, 1'b0, 64'd0, 1'b0},
        '{MODE_HALF,  64'hBFE0_0000_0000_0000, 1'b0, 64'd0, 1'b0},
        '{MODE_HALF,  64'h3FDF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 1'b0},
        '{MODE_TRUNC, 64'hBFF8_0000_0000_0000, 1'b0, 64'd0, 1'b0},
        '{MODE_FLOOR, 64'hBFF8_0000_0000_0000, 1'b0, 64'd0, 1'b0},
        '{MODE_CEIL,  64'h3FF8_0000_0000_0000, 1'b0, 64'd0, 1'b0},
        '{MODE_HALF,  64'h4330_0000_0000_0001, 1'b0, 64'd0, 1'b0},
        '{MODE_CEIL,  64'h43DF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 1'b0},
        '{MODE_HALF,  64'h433F_FFFF_FFFF_FFFF, 1'b0, 64'd0, 1'b0},
        '{MODE_FLOOR, 64'hC000_0000_0000_0001, 1'b0, 64'd0, 1'b0}
    };

    // random operand biased toward the interesting exponent range
    function automatic logic [63:0] pick_bits();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: b[62:52] = 11'($urandom_range(1000, 1090));
            5:             b[62:52] = 11'($urandom_range(1084, 1088));
            6:             b[62:52] = 11'h7FF;
            7:             b[62:52] = 11'd0;
            8:             if ($urandom_range(0, 1)) b[51:0] = '0;
            default: ;
        endcase
        return b;
    endfunction

    // one input transfer, with bursty gaps
    task automatic send_item(t_mode mode, logic [63:0] bits);
        in_ch.valid <= 1'b1;
        in_ch.op <= mode;
        in_ch.value_bits <= bits;
        conv_q.push_back(convert(mode, bits));
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_cnt++;
        @(negedge i_clk);
        if (sent_cnt % $urandom_range(1, 12) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    // receiver stall pattern
    int unsigned rx_tick = 0;
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else if (rx_tick[9:8] == 2'd0) out_ch.ready <= 1'b1;
        else out_ch.ready <= ((rx_tick % 7) < 4) || ($urandom_range(0, 3) == 0);
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_conv e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (conv_q.size() == 0) begin
                $error("unexpected result transfer %h", out_ch.result);
                fail_cnt++;
            end else begin
                e = conv_q.pop_front();
                if (out_ch.result !== e.result) begin
                    $error("result: expected %h actual %h", e.result, out_ch.result);
                    fail_cnt++;
                end
                if (out_ch.invalid !== e.invalid) begin
                    $error("invalid: expected %b actual %b", e.invalid, out_ch.invalid);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_conv got;
        in_ch.valid = 1'b0;
        in_ch.op = MODE_FLOOR;
        in_ch.value_bits = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        foreach (dir_tab[i]) begin
            // typed-in rows must agree with the predictor
            if (dir_tab[i].known) begin
                got = convert(dir_tab[i].mode, dir_tab[i].bits);
                if (got.result !== dir_tab[i].result || got.invalid !== dir_tab[i].invalid) begin
                    $error("table row %0d: expected %h/%b predicted %h/%b", i,
                           dir_tab[i].result, dir_tab[i].invalid, got.result, got.invalid);
                    fail_cnt++;
                end
            end
            send_item(dir_tab[i].mode, dir_tab[i].bits);
        end
        for (int n = 0; n < 950; n++) begin
            if (n == 400) begin
                // drain completely before resuming
                in_ch.valid <= 1'b0;
                while (conv_q.size() != 0) @(negedge i_clk);
            end
            send_item(t_mode'($urandom_range(0, 3)), pick_bits());
        end
        in_ch.valid <= 1'b0;
        while (conv_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_cnt == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
